[src/blum_integer_test_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the Blum integer test
// Shared concurrent assertion forms, clocked and disabled by reset.
// ----------------------------------------------------------------------------
`ifndef BLUM_INTEGER_TEST_ASSERT_SVH
`define BLUM_INTEGER_TEST_ASSERT_SVH

// same-cycle implication
`define BLUM_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("blum_integer_test: same-cycle check failed");

// next-cycle implication
`define BLUM_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("blum_integer_test: next-cycle check failed");

`endif

[src/blum_pkg.sv]
// ----------------------------------------------------------------------------
// Blum integer test package
// Shared constants for the sequencer and the bit-serial divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package blum_pkg;

    localparam int VALUE_WIDTH_DEF = 16;

    // first trial candidate and its square
    localparam int CAND_FIRST    = 2;
    localparam int CAND_FIRST_SQ = 4;

    // residue mod 4 that qualifies a factor
    localparam logic [1:0] RES_MOD4 = 2'd3;

endpackage

[src/blum_div.sv]
// ----------------------------------------------------------------------------
// Bit-serial divider
// Restoring division, one quotient bit per cycle; quotient and remainder
// are valid in the cycle that done is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module blum_div
    import blum_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic [VALUE_WIDTH-1:0] dividend,
    input  logic [VALUE_WIDTH-1:0] divisor,
    output logic                   busy,
    output logic                   done,
    output logic [VALUE_WIDTH-1:0] quotient,
    output logic [VALUE_WIDTH-1:0] remainder
);

    localparam int CW = $clog2(VALUE_WIDTH);

    logic                   run_reg,  run_next;
    logic                   done_reg, done_next;
    logic [CW-1:0]          cnt_reg,  cnt_next;
    logic [VALUE_WIDTH-1:0] quo_reg,  quo_next;
    logic [VALUE_WIDTH-1:0] rem_reg,  rem_next;
    logic [VALUE_WIDTH-1:0] dsr_reg,  dsr_next;
    logic [VALUE_WIDTH:0]   shifted;
    logic [VALUE_WIDTH:0]   diff;

    assign shifted = {rem_reg, quo_reg[VALUE_WIDTH-1]};
    assign diff    = shifted - {1'b0, dsr_reg};

    always_comb begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start && !run_reg) begin
            run_next = 1'b1;
            cnt_next = '0;
            quo_next = dividend;
            rem_next = '0;
            dsr_next = divisor;
        end else if (run_reg) begin
            // borrow out means the trial subtract did not fit
            quo_next = {quo_reg[VALUE_WIDTH-2:0], ~diff[VALUE_WIDTH]};
            rem_next = diff[VALUE_WIDTH] ? shifted[VALUE_WIDTH-1:0] : diff[VALUE_WIDTH-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(VALUE_WIDTH - 1)) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign busy      = run_reg;
    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

[src/blum_integer_test.sv]
// ----------------------------------------------------------------------------
// Blum integer test
// Reports whether a word is the product of two distinct primes, both 3 mod 4.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_valid / s_ready / s_value carries one word to test.
//   Result channel m_valid / m_ready / m_is_blum returns one word per input.
//   The block handles one word at a time; s_ready is high only when idle.
//   Trial candidates i run from 2 while i*i <= value. A candidate that is
//   not 3 mod 4 is skipped without a division; every trial division goes
//   through a single bit-serial divider. A dividing candidate is then checked
//   prime by trial division on the same divider, and, if prime, so is its
//   cofactor when it differs from the candidate and is 3 mod 4. The time to
//   a result therefore depends on the value.
//   The result sits in an output register: a stalled receiver holds the block
//   in its final state until the register is free, and the next word is
//   taken once the result has been handed over to that register.
//   Synchronous active-low reset empties the result register and returns the
//   sequencer to idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module blum_integer_test
    import blum_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [VALUE_WIDTH-1:0] s_value,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_is_blum
);

    `include "blum_integer_test_assert.svh"

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CAND  = 3'd1;
    localparam logic [2:0] S_CDIV  = 3'd2;
    localparam logic [2:0] S_PRIME = 3'd3;
    localparam logic [2:0] S_PDIV  = 3'd4;
    localparam logic [2:0] S_PASS  = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    localparam logic [VALUE_WIDTH-1:0] CAND_INIT    = VALUE_WIDTH'(CAND_FIRST);
    localparam logic [VALUE_WIDTH:0]   CAND_SQ_INIT = (VALUE_WIDTH + 1)'(CAND_FIRST_SQ);

    logic [2:0]             state_reg,   state_next;
    logic [VALUE_WIDTH-1:0] val_reg,     val_next;
    logic [VALUE_WIDTH-1:0] cand_reg,    cand_next;
    logic [VALUE_WIDTH:0]   cand_sq_reg, cand_sq_next;
    logic [VALUE_WIDTH-1:0] cof_reg,     cof_next;
    logic [VALUE_WIDTH-1:0] px_reg,      px_next;
    logic [VALUE_WIDTH-1:0] dv_reg,      dv_next;
    logic [VALUE_WIDTH:0]   dv_sq_reg,   dv_sq_next;
    logic                   pcof_reg,    pcof_next;
    logic                   res_reg,     res_next;
    logic                   mval_reg,    mval_next;
    logic                   mblum_reg,   mblum_next;

    logic                   div_start;
    logic [VALUE_WIDTH-1:0] div_dividend;
    logic [VALUE_WIDTH-1:0] div_divisor;
    logic                   div_busy;
    logic                   div_done;
    logic [VALUE_WIDTH-1:0] div_quo;
    logic [VALUE_WIDTH-1:0] div_rem;

    blum_div #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .busy      (div_busy),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // candidate loop dividing the value, or prime check dividing px
    assign div_dividend = (state_reg == S_CAND) ? val_reg  : px_reg;
    assign div_divisor  = (state_reg == S_CAND) ? cand_reg : dv_reg;

    assign s_ready   = (state_reg == S_IDLE);
    assign m_valid   = mval_reg;
    assign m_is_blum = mblum_reg;

    always_comb begin
        state_next   = state_reg;
        val_next     = val_reg;
        cand_next    = cand_reg;
        cand_sq_next = cand_sq_reg;
        cof_next     = cof_reg;
        px_next      = px_reg;
        dv_next      = dv_reg;
        dv_sq_next   = dv_sq_reg;
        pcof_next    = pcof_reg;
        res_next     = res_reg;
        mval_next    = mval_reg && !m_ready;
        mblum_next   = mblum_reg;
        div_start    = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    val_next     = s_value;
                    cand_next    = CAND_INIT;
                    cand_sq_next = CAND_SQ_INIT;
                    state_next   = S_CAND;
                end
            end
            S_CAND: begin
                if (cand_sq_reg > {1'b0, val_reg}) begin
                    res_next   = 1'b0;
                    state_next = S_DONE;
                end else if (cand_reg[1:0] == RES_MOD4) begin
                    div_start  = 1'b1;
                    state_next = S_CDIV;
                end else begin
                    // (i+1)^2 = i^2 + 2i + 1
                    cand_next    = cand_reg + 1'b1;
                    cand_sq_next = cand_sq_reg + {cand_reg, 1'b1};
                end
            end
            S_CDIV: begin
                if (div_done) begin
                    if (div_rem == '0) begin
                        cof_next   = div_quo;
                        px_next    = cand_reg;
                        pcof_next  = 1'b0;
                        dv_next    = CAND_INIT;
                        dv_sq_next = CAND_SQ_INIT;
                        state_next = S_PRIME;
                    end else begin
                        cand_next    = cand_reg + 1'b1;
                        cand_sq_next = cand_sq_reg + {cand_reg, 1'b1};
                        state_next   = S_CAND;
                    end
                end
            end
            S_PRIME: begin
                if (dv_sq_reg > {1'b0, px_reg}) begin
                    state_next = S_PASS;
                end else begin
                    div_start  = 1'b1;
                    state_next = S_PDIV;
                end
            end
            S_PDIV: begin
                if (div_done) begin
                    if (div_rem == '0) begin
                        // composite: carry on with the next candidate
                        cand_next    = cand_reg + 1'b1;
                        cand_sq_next = cand_sq_reg + {cand_reg, 1'b1};
                        state_next   = S_CAND;
                    end else begin
                        dv_next    = dv_reg + 1'b1;
                        dv_sq_next = dv_sq_reg + {dv_reg, 1'b1};
                        state_next = S_PRIME;
                    end
                end
            end
            S_PASS: begin
                if (pcof_reg) begin
                    res_next   = 1'b1;
                    state_next = S_DONE;
                end else if (cof_reg != cand_reg && cof_reg[1:0] == RES_MOD4) begin
                    px_next    = cof_reg;
                    pcof_next  = 1'b1;
                    dv_next    = CAND_INIT;
                    dv_sq_next = CAND_SQ_INIT;
                    state_next = S_PRIME;
                end else begin
                    cand_next    = cand_reg + 1'b1;
                    cand_sq_next = cand_sq_reg + {cand_reg, 1'b1};
                    state_next   = S_CAND;
                end
            end
            S_DONE: begin
                if (!mval_reg || m_ready) begin
                    mval_next  = 1'b1;
                    mblum_next = res_reg;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            mval_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            mval_reg  <= mval_next;
        end
    end

    always_ff @(posedge aclk) begin
        val_reg     <= val_next;
        cand_reg    <= cand_next;
        cand_sq_reg <= cand_sq_next;
        cof_reg     <= cof_next;
        px_reg      <= px_next;
        dv_reg      <= dv_next;
        dv_sq_reg   <= dv_sq_next;
        pcof_reg    <= pcof_next;
        res_reg     <= res_next;
        mblum_reg   <= mblum_next;
    end

    `BLUM_ASSERT_IMPL(a_busy_not_ready, aclk, aresetn, div_busy, !s_ready)
    `BLUM_ASSERT_NEXT(a_accept_goes_busy, aclk, aresetn, s_valid && s_ready, !s_ready)
    `BLUM_ASSERT_IMPL(a_done_in_wait, aclk, aresetn, div_done, (state_reg == S_CDIV) || (state_reg == S_PDIV))

endmodule

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// Blum integer test - testbench
// Sends words to the Blum integer test, predicts each verdict by trial
// division and compares every returned word in order. Both channels idle at
// random in three phases: receiver slow, sender slow, then neither.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import blum_pkg::*;

    localparam int VW = VALUE_WIDTH_DEF;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_valid = 1'b0;
    logic          s_ready;
    logic [VW-1:0] s_value = '0;
    logic          m_valid;
    logic          m_ready = 1'b0;
    logic          m_is_blum;

    int            sender_idle_pct = 0;
    int            recv_stall_pct = 0;
    int            error_count = 0;
    bit            blum_expected_q[$];
    int unsigned   primes_3mod4[$];
    int unsigned   primes_1mod4[$];
    int            n_small_3mod4;

    blum_integer_test #(
        .VALUE_WIDTH(VW)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_value   (s_value),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_is_blum (m_is_blum)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    initial begin
        #40_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic bit is_prime(input int unsigned x);
        int unsigned d;
        if (x < 2) return 1'b0;
        for (d = 2; d * d <= x; d++) begin
            if (x % d == 0) return 1'b0;
        end
        return 1'b1;
    endfunction

    // a candidate counts when prime, 3 mod 4 and a divisor; its cofactor must
    // then be prime, 3 mod 4 and distinct
    function automatic bit blum_predict(input logic [VW-1:0] value);
        int unsigned v;
        int unsigned co;
        int unsigned i;
        v = 32'(value);
        for (i = CAND_FIRST; i * i <= v; i++) begin
            if (i % 4 == 32'(RES_MOD4) && v % i == 0 && is_prime(i)) begin
                co = v / i;
                if (co != i && co % 4 == 32'(RES_MOD4) && is_prime(co)) return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // two distinct primes, both 3 mod 4, whose product fits the word
    function automatic int unsigned pick_blum_pair();
        int unsigned p;
        int unsigned q;
        int unsigned lim;
        int          n;
        p = primes_3mod4[$urandom_range(n_small_3mod4 - 1)];
        lim = ((1 << VW) - 1) / p;
        n = 0;
        while (n < primes_3mod4.size() && primes_3mod4[n] <= lim) n++;
        do q = primes_3mod4[$urandom_range(n - 1)]; while (q == p);
        return p * q;
    endfunction

    task automatic send_value(input logic [VW-1:0] value);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_value <= value;
        do @(posedge aclk); while (!s_ready);
        blum_expected_q.push_back(blum_predict(value));
        @(negedge aclk);
    endtask

    task automatic test_small_values();
        send_value(0);
        send_value(1);
        send_value(2);
        send_value(3);
        send_value(4);
        send_value(15);
        send_value(20);
        send_value(21);
    endtask

    task automatic test_prime_squares();
        send_value(9);
        send_value(49);
        send_value(63);
        send_value(121);
        send_value(63001);
    endtask

    task automatic test_distinct_factors();
        send_value(33);
        send_value(77);
        send_value(64769);
        send_value(65523);
    endtask

    task automatic test_width_extremes();
        send_value(16'hFFFF);
        send_value(16'h8000);
        send_value(16'h7FFF);
        send_value(16'h5555);
        send_value(16'hAAAA);
        send_value(65521);
    endtask

    task automatic test_blum_products(input int count);
        repeat (count) send_value(VW'(pick_blum_pair()));
    endtask

    // squares, a factor that is 1 mod 4, and a third factor on top
    task automatic test_near_misses(input int count);
        int unsigned p;
        int unsigned r;
        int unsigned prod;
        repeat (count) begin
            p = primes_3mod4[$urandom_range(n_small_3mod4 - 1)];
            case ($urandom_range(2))
                0: prod = p * p;
                1: begin
                    do r = primes_1mod4[$urandom_range(primes_1mod4.size() - 1)];
                    while (p * r > (1 << VW) - 1);
                    prod = p * r;
                end
                default: begin
                    prod = pick_blum_pair();
                    prod = (prod * 3 <= (1 << VW) - 1) ? prod * 3 : prod * 2;
                end
            endcase
            send_value(VW'(prod));
        end
    endtask

    task automatic test_random_values(input int count);
        repeat (count) send_value(VW'($urandom_range((1 << VW) - 1)));
    endtask

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        bit want;
        if (aresetn && m_valid && m_ready) begin
            if (blum_expected_q.size() == 0) begin
                $error("is_blum: unexpected word, expected none, actual %0b", m_is_blum);
                error_count++;
            end else begin
                want = blum_expected_q.pop_front();
                if (m_is_blum !== want) begin
                    $error("is_blum mismatch: expected %0b, actual %0b", want, m_is_blum);
                    error_count++;
                end
            end
        end
    end

    initial begin
        int unsigned x;
        for (x = 2; x <= ((1 << VW) - 1) / 3; x++) begin
            if (is_prime(x)) begin
                if (x % 4 == 32'(RES_MOD4)) primes_3mod4.push_back(x);
                else if (x % 4 == 1) primes_1mod4.push_back(x);
            end
        end
        n_small_3mod4 = 0;
        while (primes_3mod4[n_small_3mod4] * primes_3mod4[n_small_3mod4] <= (1 << VW) - 1)
            n_small_3mod4++;

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        sender_idle_pct = 36;
        recv_stall_pct = 78;
        test_small_values();
        test_prime_squares();
        test_distinct_factors();
        test_width_extremes();

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    sender_idle_pct = 36;
                    recv_stall_pct = 78;
                end
                1: begin
                    sender_idle_pct = 78;
                    recv_stall_pct = 36;
                end
                default: begin
                    sender_idle_pct = 0;
                    recv_stall_pct = 0;
                end
            endcase
            test_blum_products(30);
            test_near_misses(20);
            test_random_values(40);
        end
        s_valid <= 1'b0;

        while (blum_expected_q.size() != 0) @(posedge aclk);
        repeat (64) @(posedge aclk);
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+src
src/blum_pkg.sv
src/blum_div.sv
src/blum_integer_test.sv
test/tb_top.sv
